>>> hdl/two_class_ticket_queue_macros.svh
// assertion macros used by the checker file
`ifndef TWO_CLASS_TICKET_QUEUE_MACROS_SVH
`define TWO_CLASS_TICKET_QUEUE_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define TTQ_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("two_class_ticket_queue: same-cycle check failed");

// next-cycle implication, clocked on clock, off during reset
`define TTQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("two_class_ticket_queue: next-cycle check failed");

`endif

>>> hdl/ttq_pkg.sv
`timescale 1ns / 1ps
package ttq_pkg;

   localparam int QUEUE_DEPTH  = 64;
   localparam int TICKET_LIMIT = 999;

   localparam int TICKET_W  = 10;
   localparam int COUNTER_W = 8;
   localparam int STATUS_W  = 3;

   // occupancy map, one bit per ticket code
   localparam int MAP_DEPTH = 1 << TICKET_W;
   localparam int MAP_AW    = TICKET_W;

   // ticket store: class bit on top of the slot index
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = 2 * (1 << QPTR_W);
   localparam int STORE_AW    = QPTR_W + 1;

   localparam logic MODE_ENQUEUE   = 1'b0;
   localparam logic MODE_CALL      = 1'b1;
   localparam logic CLASS_NORMAL   = 1'b0;
   localparam logic CLASS_PRIORITY = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ENQUEUED  = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_CALLED    = 3'd3,
      STAT_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic cls;
   } ptr_cmd_type;

   typedef struct packed {
      logic              prio_nz;
      logic              norm_nz;
      logic              prio_full;
      logic              norm_full;
      logic [QPTR_W-1:0] prio_head;
      logic [QPTR_W-1:0] prio_tail;
      logic [QPTR_W-1:0] norm_head;
      logic [QPTR_W-1:0] norm_tail;
   } ptr_stat_type;

   function automatic logic [QPTR_W-1:0] slot_next(input logic [QPTR_W-1:0] pos);
      logic [QPTR_W-1:0] res;
      if (pos == QPTR_W'(QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = pos + QPTR_W'(1);
      end
      return res;
   endfunction

endpackage

>>> hdl/ttq_ram.sv
`timescale 1ns / 1ps
module ttq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ttq_ptr.sv
`timescale 1ns / 1ps
module ttq_ptr (
   input  logic                 clock,
   input  logic                 reset,
   input  ttq_pkg::ptr_cmd_type cmd,
   output ttq_pkg::ptr_stat_type stat
);
   import ttq_pkg::*;

   logic [QPTR_W-1:0] prio_head_ff, prio_head_in, prio_tail_ff, prio_tail_in;
   logic [QPTR_W-1:0] norm_head_ff, norm_head_in, norm_tail_ff, norm_tail_in;
   logic [QCNT_W-1:0] prio_cnt_ff, prio_cnt_in, norm_cnt_ff, norm_cnt_in;

   always_comb begin
      prio_head_in = prio_head_ff;
      prio_tail_in = prio_tail_ff;
      prio_cnt_in  = prio_cnt_ff;
      norm_head_in = norm_head_ff;
      norm_tail_in = norm_tail_ff;
      norm_cnt_in  = norm_cnt_ff;
      if (cmd.push) begin
         if (cmd.cls == CLASS_PRIORITY) begin
            prio_tail_in = slot_next(prio_tail_ff);
            prio_cnt_in  = prio_cnt_ff + QCNT_W'(1);
         end else begin
            norm_tail_in = slot_next(norm_tail_ff);
            norm_cnt_in  = norm_cnt_ff + QCNT_W'(1);
         end
      end else if (cmd.pop) begin
         if (cmd.cls == CLASS_PRIORITY) begin
            prio_head_in = slot_next(prio_head_ff);
            prio_cnt_in  = prio_cnt_ff - QCNT_W'(1);
         end else begin
            norm_head_in = slot_next(norm_head_ff);
            norm_cnt_in  = norm_cnt_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_head_ff <= '0;
         prio_tail_ff <= '0;
         prio_cnt_ff  <= '0;
         norm_head_ff <= '0;
         norm_tail_ff <= '0;
         norm_cnt_ff  <= '0;
      end else begin
         prio_head_ff <= prio_head_in;
         prio_tail_ff <= prio_tail_in;
         prio_cnt_ff  <= prio_cnt_in;
         norm_head_ff <= norm_head_in;
         norm_tail_ff <= norm_tail_in;
         norm_cnt_ff  <= norm_cnt_in;
      end
   end

   always_comb begin
      stat.prio_nz   = (prio_cnt_ff != '0);
      stat.norm_nz   = (norm_cnt_ff != '0);
      stat.prio_full = (prio_cnt_ff == QCNT_W'(QUEUE_DEPTH));
      stat.norm_full = (norm_cnt_ff == QCNT_W'(QUEUE_DEPTH));
      stat.prio_head = prio_head_ff;
      stat.prio_tail = prio_tail_ff;
      stat.norm_head = norm_head_ff;
      stat.norm_tail = norm_tail_ff;
   end

endmodule

>>> hdl/two_class_ticket_queue.sv
// two-class ticket queue: priority fifo served before normal fifo, duplicate check by map
// result: memories read on acceptance, then registered when the response register is free
// one request at a time: the next waits for the read then write-back of the memories
// reset: synchronous; then a clearing pass over all 1024 occupancy map entries, req_stall high
// fifo pointers and counts clear at once; ticket store contents stay undefined
`timescale 1ns / 1ps
module two_class_ticket_queue (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [ttq_pkg::TICKET_W-1:0]    req_ticket_number,
   input  logic                            req_is_priority,
   input  logic [ttq_pkg::COUNTER_W-1:0]   req_counter_id,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ttq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ttq_pkg::TICKET_W-1:0]    rsp_called_ticket,
   output logic                            rsp_called_priority,
   output logic [ttq_pkg::COUNTER_W-1:0]   rsp_called_counter
);
   import ttq_pkg::*;

   // sequencer state and clearing sweep
   state_type         state_ff, state_in;
   logic [MAP_AW-1:0] clr_ff, clr_in;
   logic              clearing, executing, clr_done;

   // request captured at acceptance (payload, no reset)
   logic                 mode_ff, prio_ff;
   logic [TICKET_W-1:0]  ticket_ff;
   logic [COUNTER_W-1:0] counter_ff;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [TICKET_W-1:0]  called_ticket_ff, called_ticket_in;
   logic                 called_prio_ff, called_prio_in;
   logic [COUNTER_W-1:0] called_counter_ff, called_counter_in;

   logic accept, out_free, finish;

   // fifo bookkeeping
   ptr_cmd_type  ptr_cmd;
   ptr_stat_type ptr_stat;

   // ticket store port signals
   logic                st_wr_en, st_rd_en;
   logic [STORE_AW-1:0] st_wr_addr, st_rd_addr;
   logic [TICKET_W-1:0] st_rd_data;

   // occupancy map port signals
   logic              map_wr_en;
   logic [MAP_AW-1:0] map_wr_addr;
   logic [0:0]        map_wr_data, map_rd_data;

   // decode of the request being executed
   logic ticket_bad, class_full, call_any, call_cls, do_push, do_pop;

   // ---------------------------------------------------------------- sequencer
   assign clr_done = (clr_ff == MAP_AW'(MAP_DEPTH - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold here until the response register can take the result
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state decode
   always_comb begin
      req_stall = 1'b1;
      clearing  = 1'b0;
      executing = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_EXEC: begin
            executing = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign clr_in = clearing ? clr_ff + MAP_AW'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // ---------------------------------------------------------------- handshakes
   assign accept   = req_valid && !req_stall;
   // the response register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = executing && out_free;

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_mode;
         prio_ff    <= req_is_priority;
         ticket_ff  <= req_ticket_number;
         counter_ff <= req_counter_id;
      end
   end

   // ---------------------------------------------------------------- read phase
   // on acceptance both memories are read: the map at the offered ticket and the
   // store at the head of the class that a call would serve; read data then holds
   // until the next transaction is taken
   assign st_rd_en   = accept;
   assign st_rd_addr = ptr_stat.prio_nz ? {CLASS_PRIORITY, ptr_stat.prio_head}
                                        : {CLASS_NORMAL, ptr_stat.norm_head};

   // ---------------------------------------------------------------- modify / write-back
   assign ticket_bad = (ticket_ff == '0) || (32'(ticket_ff) > 32'(TICKET_LIMIT))
                       || map_rd_data[0];
   assign class_full = (prio_ff == CLASS_PRIORITY) ? ptr_stat.prio_full : ptr_stat.norm_full;
   assign call_any   = ptr_stat.prio_nz || ptr_stat.norm_nz;
   assign call_cls   = ptr_stat.prio_nz ? CLASS_PRIORITY : CLASS_NORMAL;

   assign do_push = finish && (mode_ff == MODE_ENQUEUE) && !ticket_bad && !class_full;
   assign do_pop  = finish && (mode_ff == MODE_CALL) && call_any;

   always_comb begin
      ptr_cmd.push = do_push;
      ptr_cmd.pop  = do_pop;
      ptr_cmd.cls  = (mode_ff == MODE_CALL) ? call_cls : prio_ff;
   end

   // enqueue writes the ticket at the tail of its class
   assign st_wr_en   = do_push;
   assign st_wr_addr = (prio_ff == CLASS_PRIORITY) ? {CLASS_PRIORITY, ptr_stat.prio_tail}
                                                  : {CLASS_NORMAL, ptr_stat.norm_tail};

   // map: clearing sweep, mark on enqueue, release on call
   always_comb begin
      map_wr_en   = 1'b0;
      map_wr_addr = ticket_ff;
      map_wr_data = 1'b0;
      if (clearing) begin
         map_wr_en   = 1'b1;
         map_wr_addr = clr_ff;
      end else if (do_push) begin
         map_wr_en   = 1'b1;
         map_wr_data = 1'b1;
      end else if (do_pop) begin
         map_wr_en   = 1'b1;
         map_wr_addr = st_rd_data;
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      status_in         = STAT_EMPTY;
      called_ticket_in  = '0;
      called_prio_in    = 1'b0;
      called_counter_in = '0;
      if (mode_ff == MODE_ENQUEUE) begin
         if (ticket_bad) begin
            status_in = STAT_DUPLICATE;
         end else if (class_full) begin
            status_in = STAT_FULL;
         end else begin
            status_in = STAT_ENQUEUED;
         end
      end else if (call_any) begin
         status_in         = STAT_CALLED;
         called_ticket_in  = st_rd_data;
         called_prio_in    = call_cls;
         called_counter_in = counter_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff         <= status_in;
         called_ticket_ff  <= called_ticket_in;
         called_prio_ff    <= called_prio_in;
         called_counter_ff <= called_counter_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_called_ticket   = called_ticket_ff;
   assign rsp_called_priority = called_prio_ff;
   assign rsp_called_counter  = called_counter_ff;

   // ---------------------------------------------------------------- instances
   ttq_ptr u_ptr (
      .clock (clock),
      .reset (reset),
      .cmd   (ptr_cmd),
      .stat  (ptr_stat)
   );

   // both classes share one store, class bit on top of the address
   ttq_ram #(
      .WIDTH (TICKET_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (ticket_ff),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   ttq_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (accept),
      .rd_addr (req_ticket_number),
      .rd_data (map_rd_data)
   );

endmodule

>>> hdl/ttq_checker.sv
`timescale 1ns / 1ps
`include "two_class_ticket_queue_macros.svh"
module ttq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ttq_pkg::STATUS_W-1:0]  rsp_status,
   input logic [ttq_pkg::TICKET_W-1:0]  rsp_called_ticket,
   input logic                          rsp_called_priority,
   input logic [ttq_pkg::COUNTER_W-1:0] rsp_called_counter
);
   import ttq_pkg::*;

   // one transaction at a time: stall rises right after a request is taken
   `TTQ_ASSERT_NEXT(a_stall_after_accept, req_valid && !req_stall, req_stall)

   // only a successful call carries ticket, class and counter
   `TTQ_ASSERT_IMPL(a_fields_zero, rsp_valid && (rsp_status != STAT_CALLED), (rsp_called_ticket == '0) && !rsp_called_priority && (rsp_called_counter == '0))

   // a called ticket was enqueued, so it lies in the legal range
   `TTQ_ASSERT_IMPL(a_called_legal, rsp_valid && (rsp_status == STAT_CALLED), (rsp_called_ticket != '0) && (32'(rsp_called_ticket) <= 32'(TICKET_LIMIT)))

   // a stalled response holds its valid, status and called ticket
   `TTQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_called_ticket))

endmodule

bind two_class_ticket_queue ttq_checker u_ttq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_called_ticket   (rsp_called_ticket),
   .rsp_called_priority (rsp_called_priority),
   .rsp_called_counter  (rsp_called_counter)
);

>>> test/two_class_ticket_queue_tb.sv
`timescale 1ns / 1ps
module two_class_ticket_queue_tb;
   import ttq_pkg::*;

   localparam int RANDOM_ITEMS  = 650;
   localparam int MAX_WAIT      = 12;
   localparam int SETTLE_CYCLES = 10;
   localparam int REPORT_LIMIT  = 10;
   localparam int RECENT_KEPT   = 32;

   // one request transaction as the sender holds it, with its own idle gap
   typedef struct {
      logic                 mode;
      logic [TICKET_W-1:0]  ticket;
      logic                 cls;
      logic [COUNTER_W-1:0] counter;
      int unsigned          gap;
      bit                   drain;   // hold back until every outstanding result is in
   } ticket_request_type;

   // one response transaction, packed so that a single 4-state compare covers all fields
   typedef struct packed {
      status_type           status;
      logic [TICKET_W-1:0]  ticket;
      logic                 cls;
      logic [COUNTER_W-1:0] counter;
   } service_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_mode = MODE_ENQUEUE;
   logic [TICKET_W-1:0]  req_ticket_number = '0;
   logic                 req_is_priority = CLASS_NORMAL;
   logic [COUNTER_W-1:0] req_counter_id = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [TICKET_W-1:0]  rsp_called_ticket;
   logic                 rsp_called_priority;
   logic [COUNTER_W-1:0] rsp_called_counter;

   two_class_ticket_queue dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_ticket_number   (req_ticket_number),
      .req_is_priority     (req_is_priority),
      .req_counter_id      (req_counter_id),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_called_ticket   (rsp_called_ticket),
      .rsp_called_priority (rsp_called_priority),
      .rsp_called_counter  (rsp_called_counter)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor: its own picture of both classes and of the waiting tickets
   // ---------------------------------------------------------------------
   logic [TICKET_W-1:0] priority_line[$];
   logic [TICKET_W-1:0] normal_line[$];
   bit                  ticket_held [MAP_DEPTH];
   service_result_type  outcomes_due[$];
   int unsigned         mismatches = 0;

   // works out the response to one accepted request and updates the picture
   function automatic service_result_type serve_request(input logic mode,
                                                        input logic [TICKET_W-1:0] tkt,
                                                        input logic cls,
                                                        input logic [COUNTER_W-1:0] ctr);
      service_result_type res;
      int unsigned        fill;
      res = '0;
      if (mode == MODE_ENQUEUE) begin
         fill = (cls == CLASS_PRIORITY) ? priority_line.size() : normal_line.size();
         // out-of-range numbers share the duplicate status, and it wins over full
         if (tkt == 0 || tkt > TICKET_LIMIT || ticket_held[tkt]) begin
            res.status = STAT_DUPLICATE;
         end else if (fill >= QUEUE_DEPTH) begin
            res.status = STAT_FULL;
         end else begin
            if (cls == CLASS_PRIORITY) begin
               priority_line.push_back(tkt);
            end else begin
               normal_line.push_back(tkt);
            end
            ticket_held[tkt] = 1'b1;
            res.status = STAT_ENQUEUED;
         end
      end else if (priority_line.size() == 0 && normal_line.size() == 0) begin
         res.status = STAT_EMPTY;
      end else begin
         // priority class is always served first, each class in arrival order
         if (priority_line.size() != 0) begin
            res.ticket = priority_line.pop_front();
            res.cls    = CLASS_PRIORITY;
         end else begin
            res.ticket = normal_line.pop_front();
            res.cls    = CLASS_NORMAL;
         end
         ticket_held[res.ticket] = 1'b0;
         res.status  = STAT_CALLED;
         res.counter = ctr;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus build-up
   // ---------------------------------------------------------------------
   ticket_request_type  pending[$];
   bit                  sender_quick;
   int unsigned         waiting_bound = 0;   // upper bound on tickets still queued
   logic [TICKET_W-1:0] recent_tickets[$];   // source of deliberate duplicates

   // ctr below zero means a random counter number
   task automatic push_request(input logic mode, input logic [TICKET_W-1:0] tkt,
                               input logic cls, input bit drain = 1'b0,
                               input int ctr = -1);
      ticket_request_type rq;
      rq.mode    = mode;
      rq.ticket  = tkt;
      rq.cls     = cls;
      rq.counter = (ctr < 0) ? COUNTER_W'($urandom_range(0, (1 << COUNTER_W) - 1))
                             : COUNTER_W'(ctr);
      rq.gap     = sender_quick ? 0 : $urandom_range(0, MAX_WAIT);
      rq.drain   = drain;
      pending.push_back(rq);
      if (mode == MODE_ENQUEUE) begin
         if (waiting_bound < 2 * QUEUE_DEPTH) waiting_bound++;
         recent_tickets.push_back(tkt);
         if (recent_tickets.size() > RECENT_KEPT) void'(recent_tickets.pop_front());
      end else if (waiting_bound != 0) begin
         waiting_bound--;
      end
   endtask

   // call transaction; ticket and class fields are don't-care, so randomise them
   task automatic push_call(input bit drain = 1'b0);
      push_request(MODE_CALL, TICKET_W'($urandom_range(0, MAP_DEPTH - 1)),
                   1'($urandom_range(0, 1)), drain);
   endtask

   // enough calls to be sure both classes end up empty, plus one on empty
   task automatic drain_all(input bit drain);
      int unsigned n;
      n = waiting_bound + 1;
      for (int k = 0; k < n; k++) push_call(drain && k == 0);
   endtask

   function automatic logic [TICKET_W-1:0] pick_ticket();
      int unsigned roll;
      roll = $urandom_range(1, 100);
      if (roll <= 12 && recent_tickets.size() != 0) begin
         return recent_tickets[$urandom_range(0, recent_tickets.size() - 1)];
      end
      if (roll <= 16) return '0;
      if (roll <= 20) return TICKET_W'($urandom_range(TICKET_LIMIT + 1, MAP_DEPTH - 1));
      return TICKET_W'($urandom_range(1, TICKET_LIMIT));
   endfunction

   // run one class past full from empty, with the pointers wherever traffic left them
   task automatic fill_class(input logic cls);
      int unsigned base;
      drain_all(1'b1);
      base = $urandom_range(1, TICKET_LIMIT - QUEUE_DEPTH - 2);
      for (int k = 0; k < QUEUE_DEPTH + 2; k++) begin
         push_request(MODE_ENQUEUE, TICKET_W'(base + k), cls);
      end
      push_request(MODE_ENQUEUE, TICKET_W'(base), cls);   // duplicate into a full class
      push_request(MODE_ENQUEUE, TICKET_W'(base + QUEUE_DEPTH + 2), !cls);
      drain_all(1'b0);
   endtask

   task automatic build_stimulus();
      int unsigned random_start;
      int unsigned fills_done;
      int unsigned len;
      int unsigned call_pct;
      int unsigned prio_pct;
      bit          first;
      bit          d;

      // directed opening: range edges, cross-class duplicates, ordering, counter echo
      sender_quick = 1'b1;
      push_request(MODE_CALL, TICKET_W'(MAP_DEPTH - 1), CLASS_PRIORITY, 1'b0, 255); // empty
      push_request(MODE_ENQUEUE, TICKET_W'(0), CLASS_NORMAL);               // ticket zero
      push_request(MODE_ENQUEUE, TICKET_W'(TICKET_LIMIT + 1), CLASS_PRIORITY); // above range
      push_request(MODE_ENQUEUE, TICKET_W'(MAP_DEPTH - 1), CLASS_NORMAL);   // all ones
      push_request(MODE_ENQUEUE, TICKET_W'(1), CLASS_NORMAL);
      push_request(MODE_ENQUEUE, TICKET_W'(TICKET_LIMIT), CLASS_PRIORITY);
      push_request(MODE_ENQUEUE, TICKET_W'(TICKET_LIMIT), CLASS_NORMAL);    // held in other class
      push_request(MODE_ENQUEUE, TICKET_W'(1), CLASS_PRIORITY);
      push_request(MODE_ENQUEUE, TICKET_W'(512), CLASS_NORMAL);
      push_request(MODE_CALL, TICKET_W'(0), CLASS_NORMAL, 1'b0, 0);         // counter zero
      push_request(MODE_CALL, TICKET_W'(0), CLASS_NORMAL, 1'b0, 255);
      push_request(MODE_ENQUEUE, TICKET_W'(1), CLASS_PRIORITY);             // number reused
      push_request(MODE_CALL, TICKET_W'(MAP_DEPTH - 1), CLASS_PRIORITY, 1'b0, 1);
      push_call();
      push_call();                                                          // empty again

      // random part: mixed episodes, two fill-to-full runs, regular drains
      random_start = pending.size();
      fills_done   = 0;
      first        = 1'b1;
      while (pending.size() < random_start + RANDOM_ITEMS) begin
         sender_quick = ($urandom_range(0, 3) == 0);
         if (fills_done < 2 && pending.size() >= random_start + 150 + 250 * fills_done) begin
            fill_class(fills_done == 0 ? CLASS_PRIORITY : CLASS_NORMAL);
            fills_done++;
         end else begin
            len      = $urandom_range(8, 40);
            call_pct = $urandom_range(20, 70);
            prio_pct = $urandom_range(10, 90);
            for (int k = 0; k < len; k++) begin
               d = (k == 0) && (first || $urandom_range(0, 3) == 0);
               if ($urandom_range(1, 100) <= call_pct) begin
                  push_call(d);
               end else begin
                  push_request(MODE_ENQUEUE, pick_ticket(),
                               ($urandom_range(1, 100) <= prio_pct) ? CLASS_PRIORITY
                                                                    : CLASS_NORMAL, d);
               end
            end
            first = 1'b0;
            if ($urandom_range(0, 2) == 0) drain_all(1'b0);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // handshake tracking: which channel moved a transaction at the last edge
   // ---------------------------------------------------------------------
   bit req_fired = 1'b0;
   bit rsp_fired = 1'b0;

   // request driver, falling edge
   ticket_request_type staged;
   bit                 armed = 1'b0;
   int unsigned        send_wait = 0;

   always @(negedge clock) begin
      bit raise;
      raise = 1'b0;
      if (!reset && !(req_valid && !req_fired)) begin
         // nothing held: fetch the next request and count down its gap
         if (!armed && pending.size() != 0) begin
            staged    = pending.pop_front();
            armed     = 1'b1;
            send_wait = staged.gap;
         end
         if (armed) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (!(staged.drain && outcomes_due.size() != 0)) begin
               raise             = 1'b1;
               armed             = 1'b0;
               req_mode          <= staged.mode;
               req_ticket_number <= staged.ticket;
               req_is_priority   <= staged.cls;
               req_counter_id    <= staged.counter;
            end
         end
         req_valid <= raise;
      end
   end

   // response stall driver, falling edge: a fresh wait drawn after every result taken
   bit          rsp_burst = 1'b0;
   int unsigned stall_left = 0;

   always @(negedge clock) begin
      if (rsp_fired) begin
         if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
         stall_left = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor, rising edge: predict on request accept, then check any response taken
   always @(posedge clock) begin
      service_result_type seen;
      service_result_type wanted;
      req_fired <= !reset && req_valid && !req_stall;
      rsp_fired <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            outcomes_due.push_back(serve_request(req_mode, req_ticket_number,
                                                 req_is_priority, req_counter_id));
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_status, rsp_called_ticket, rsp_called_priority, rsp_called_counter};
            if (outcomes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: response with none outstanding: status %0d ticket %0d",
                           $realtime, seen.status, seen.ticket);
               end
            end else begin
               wanted = outcomes_due.pop_front();
               if (seen !== wanted) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: exp/act st %0d/%0d tkt %0d/%0d cls %0b/%0b ctr %0d/%0d",
                              $realtime, wanted.status, seen.status, wanted.ticket,
                              seen.ticket, wanted.cls, seen.cls, wanted.counter,
                              seen.counter);
                  end
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequencing: reset, run, wait for the last response, verdict
   // ---------------------------------------------------------------------
   initial begin
      build_stimulus();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // clearing pass after reset shows up as req_stall, the driver simply waits
      while (pending.size() != 0 || armed || req_valid) @(posedge clock);
      while (outcomes_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && outcomes_due.size() == 0) begin
         $display("two_class_ticket_queue_tb: clean");
      end else begin
         $display("two_class_ticket_queue_tb: errors");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("two_class_ticket_queue_tb: errors");
      $finish;
   end

endmodule

>>> two_class_ticket_queue.f
+incdir+hdl
hdl/ttq_pkg.sv
hdl/ttq_ram.sv
hdl/ttq_ptr.sv
hdl/two_class_ticket_queue.sv
hdl/ttq_checker.sv
test/two_class_ticket_queue_tb.sv
